// ===== design/pmds_pkg.sv =====
`default_nettype none
package pmds_pkg;

	// search limits
	localparam int MAX_MULT = 74;
	localparam int MAX_DIV  = 63;

	// field widths
	localparam int FREQ_W = 20;
	localparam int MULT_W = 7;
	localparam int DIV_W  = 6;
	localparam int VCO_W  = FREQ_W + MULT_W;

	// divider: quotient bits resolved per cycle
	localparam int STEP_BITS = 3;
	localparam int DIV_STEPS = (VCO_W + STEP_BITS - 1) / STEP_BITS;
	localparam int QP_W      = DIV_STEPS * STEP_BITS;
	localparam int STEP_CW   = $clog2(DIV_STEPS);

	// configuration register map
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;
	localparam logic REG_VCO_MIN = 1'b0;
	localparam logic REG_VCO_MAX = 1'b1;

	// register reset values
	localparam logic [FREQ_W-1:0] VCO_MIN_RST = FREQ_W'(400000);
	localparam logic [FREQ_W-1:0] VCO_MAX_RST = FREQ_W'(1000000);

	typedef struct packed {
		logic [FREQ_W-1:0] ref_khz;
		logic [FREQ_W-1:0] goal_khz;
	} in_item_t;

	typedef struct packed {
		logic [MULT_W-1:0] best_mult;
		logic [DIV_W-1:0]  best_div;
		logic [FREQ_W-1:0] best_err_khz;
		logic              found;
	} out_item_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic mul;
		logic mult_next;
		logic mult_start;
		logic div_start;
		logic div_step;
		logic div_next;
		logic eval;
		logic publish;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic vco_above;
		logic vco_below;
		logic mult_last;
		logic div_last;
		logic div_done;
		logic err_worse;
	} stat_t;

endpackage
`default_nettype wire

// ===== design/pmds_regs.sv =====
`default_nettype none
module pmds_regs (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [pmds_pkg::ADDR_W-1:0]  paddr,
	input  wire logic [pmds_pkg::DATA_W-1:0]  pwdata,
	output logic      [pmds_pkg::DATA_W-1:0]  prdata,
	output logic                              pready,
	output logic      [pmds_pkg::FREQ_W-1:0]  vco_min,
	output logic      [pmds_pkg::FREQ_W-1:0]  vco_max
);
	import pmds_pkg::*;

	logic [FREQ_W-1:0] vco_min_q;
	logic [FREQ_W-1:0] vco_max_q;
	logic              wr_en;
	logic              reg_sel;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_sel = paddr[2];

	// register writes on the access beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vco_min_q <= VCO_MIN_RST;
			vco_max_q <= VCO_MAX_RST;
		end else if (wr_en) begin
			case (reg_sel)
				REG_VCO_MIN: vco_min_q <= pwdata[FREQ_W-1:0];
				REG_VCO_MAX: vco_max_q <= pwdata[FREQ_W-1:0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		case (reg_sel)
			REG_VCO_MIN: prdata = DATA_W'(vco_min_q);
			REG_VCO_MAX: prdata = DATA_W'(vco_max_q);
			default:     prdata = '0;
		endcase
	end

	assign vco_min = vco_min_q;
	assign vco_max = vco_max_q;

endmodule
`default_nettype wire

// ===== design/pmds_ctrl.sv =====
`default_nettype none
module pmds_ctrl (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            in_valid,
	output logic                 in_stall,
	output logic                 out_valid,
	input  wire logic            out_stall,
	input  wire pmds_pkg::stat_t stat,
	output pmds_pkg::cmd_t       cmd
);
	import pmds_pkg::*;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_MUL    = 3'd1;
	localparam logic [2:0] ST_CHECK  = 3'd2;
	localparam logic [2:0] ST_DIV    = 3'd3;
	localparam logic [2:0] ST_EVAL   = 3'd4;
	localparam logic [2:0] ST_FINISH = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_d;
	logic       out_valid_q;
	logic       slot_free;
	logic       in_acc;

	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && (state_q == ST_IDLE);
	assign slot_free = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;

	// next state and datapath commands
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (in_acc) begin
					cmd.load = 1'b1;
					state_d  = ST_MUL;
				end
			end
			ST_MUL: begin
				cmd.mul = 1'b1;
				state_d = ST_CHECK;
			end
			ST_CHECK: begin
				if (stat.vco_above) begin
					if (stat.mult_last) begin
						state_d = ST_FINISH;
					end else begin
						cmd.mult_next = 1'b1;
						state_d       = ST_MUL;
					end
				end else if (stat.vco_below) begin
					state_d = ST_FINISH;
				end else begin
					cmd.mult_start = 1'b1;
					cmd.div_start  = 1'b1;
					state_d        = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_done) begin
					state_d = ST_EVAL;
				end
			end
			ST_EVAL: begin
				cmd.eval = 1'b1;
				if (stat.err_worse || stat.div_last) begin
					if (stat.mult_last) begin
						state_d = ST_FINISH;
					end else begin
						cmd.mult_next = 1'b1;
						state_d       = ST_MUL;
					end
				end else begin
					cmd.div_next  = 1'b1;
					cmd.div_start = 1'b1;
					state_d       = ST_DIV;
				end
			end
			ST_FINISH: begin
				if (slot_free) begin
					cmd.publish = 1'b1;
					state_d     = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state and result beat valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.publish) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

// ===== design/pmds_dp.sv =====
`default_nettype none
module pmds_dp (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire pmds_pkg::cmd_t              cmd,
	output pmds_pkg::stat_t                  stat,
	input  wire pmds_pkg::in_item_t          in_data,
	input  wire logic [pmds_pkg::FREQ_W-1:0] vco_min,
	input  wire logic [pmds_pkg::FREQ_W-1:0] vco_max,
	output pmds_pkg::out_item_t              out_data
);
	import pmds_pkg::*;

	logic [FREQ_W-1:0]  ref_q;
	logic [FREQ_W-1:0]  goal_q;
	logic [MULT_W-1:0]  mult_q;
	logic [VCO_W-1:0]   vco_q;
	logic [DIV_W-1:0]   div_q;
	logic [DIV_W-1:0]   rem_q;
	logic [QP_W-1:0]    quo_q;
	logic [STEP_CW-1:0] step_q;
	logic [VCO_W-1:0]   prev_e_q;
	logic               prev_valid_q;
	logic [MULT_W-1:0]  best_m_q;
	logic [DIV_W-1:0]   best_d_q;
	logic [VCO_W-1:0]   best_e_q;
	logic               have_q;
	out_item_t          out_q;

	logic [DIV_W-1:0]   rem_d;
	logic [QP_W-1:0]    quo_d;
	logic [DIV_W:0]     trial;
	logic [VCO_W-1:0]   quot;
	logic [VCO_W-1:0]   goal_x;
	logic [VCO_W-1:0]   err;
	logic               better;

	// restoring division, several quotient bits per cycle
	always_comb begin
		rem_d = rem_q;
		quo_d = quo_q;
		trial = '0;
		for (int i = 0; i < STEP_BITS; i++) begin
			trial = {rem_d, quo_d[QP_W-1]};
			quo_d = {quo_d[QP_W-2:0], 1'b0};
			if (trial >= {1'b0, div_q}) begin
				trial    = trial - {1'b0, div_q};
				quo_d[0] = 1'b1;
			end
			rem_d = trial[DIV_W-1:0];
		end
	end

	// error of the current quotient against the goal
	assign quot   = quo_q[VCO_W-1:0];
	assign goal_x = VCO_W'(goal_q);
	assign err    = (quot > goal_x) ? (quot - goal_x) : (goal_x - quot);
	assign better = !have_q || (err < best_e_q);

	// status back to the controller
	assign stat.vco_above = vco_q > VCO_W'(vco_max);
	assign stat.vco_below = vco_q < VCO_W'(vco_min);
	assign stat.mult_last = (mult_q == MULT_W'(1));
	assign stat.div_last  = (div_q == DIV_W'(MAX_DIV));
	assign stat.div_done  = (step_q == STEP_CW'(DIV_STEPS - 1));
	assign stat.err_worse = prev_valid_q && (err > prev_e_q);

	// search datapath registers
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			ref_q  <= in_data.ref_khz;
			goal_q <= in_data.goal_khz;
			mult_q <= MULT_W'(MAX_MULT);
		end
		if (cmd.mul) begin
			vco_q <= VCO_W'(ref_q) * VCO_W'(mult_q);
		end
		if (cmd.mult_next) begin
			mult_q <= mult_q - MULT_W'(1);
		end
		if (cmd.mult_start) begin
			div_q <= DIV_W'(1);
		end
		if (cmd.div_next) begin
			div_q <= div_q + DIV_W'(1);
		end
		if (cmd.div_start) begin
			rem_q  <= '0;
			quo_q  <= QP_W'(vco_q);
			step_q <= '0;
		end
		if (cmd.div_step) begin
			rem_q  <= rem_d;
			quo_q  <= quo_d;
			step_q <= step_q + STEP_CW'(1);
		end
		if (cmd.eval && !stat.err_worse) begin
			prev_e_q <= err;
			if (better) begin
				best_m_q <= mult_q;
				best_d_q <= div_q;
				best_e_q <= err;
			end
		end
		if (cmd.publish) begin
			if (have_q) begin
				out_q.best_mult    <= best_m_q;
				out_q.best_div     <= best_d_q;
				out_q.best_err_khz <= best_e_q[FREQ_W-1:0];
				out_q.found        <= 1'b1;
			end else begin
				out_q.best_mult    <= '0;
				out_q.best_div     <= '0;
				out_q.best_err_khz <= '1;
				out_q.found        <= 1'b0;
			end
		end
	end

	// search control flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q       <= 1'b0;
			prev_valid_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				have_q <= 1'b0;
			end else if (cmd.eval && !stat.err_worse) begin
				have_q <= 1'b1;
			end
			if (cmd.mult_start) begin
				prev_valid_q <= 1'b0;
			end else if (cmd.eval && !stat.err_worse) begin
				prev_valid_q <= 1'b1;
			end
		end
	end

	assign out_data = out_q;

endmodule
`default_nettype wire

// ===== design/pll_mult_div_search.sv =====
// channel  | direction | handshake          | payload
// ---------+-----------+--------------------+-----------------------------------------
// in       | input     | in_valid/in_stall   | ref_khz, goal_khz
// out      | output    | out_valid/out_stall | best_mult, best_div, best_err_khz, found
// apb      | input     | psel/penable/pready | vco_min_khz at 0x0, vco_max_khz at 0x4
//
// one beat in at a time; each multiplier tried takes a multiply and a range check, and each
// divider tried takes 9 divider steps of 3 quotient bits, then an error compare; the result
// beat is registered once the search finishes and the output slot is free, and the next
// input can be taken at the earliest in the cycle that the result beat turns valid.
// the output register holds a finished beat, so the next input is taken while it waits.
// reset clears the controller and restores the vco limits; no clearing pass.
`default_nettype none
module pll_mult_div_search (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        in_valid,
	output logic                             in_stall,
	input  wire pmds_pkg::in_item_t          in_data,
	output logic                             out_valid,
	input  wire logic                        out_stall,
	output pmds_pkg::out_item_t              out_data,
	input  wire logic                        psel,
	input  wire logic                        penable,
	input  wire logic                        pwrite,
	input  wire logic [pmds_pkg::ADDR_W-1:0] paddr,
	input  wire logic [pmds_pkg::DATA_W-1:0] pwdata,
	output logic      [pmds_pkg::DATA_W-1:0] prdata,
	output logic                             pready
);
	import pmds_pkg::*;

	cmd_t              cmd;
	stat_t             stat;
	logic [FREQ_W-1:0] vco_min;
	logic [FREQ_W-1:0] vco_max;

	// configuration registers
	pmds_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.vco_min (vco_min),
		.vco_max (vco_max)
	);

	// search sequencer
	pmds_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.stat      (stat),
		.cmd       (cmd)
	);

	// multiply, divide and compare
	pmds_dp u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.stat     (stat),
		.in_data  (in_data),
		.vco_min  (vco_min),
		.vco_max  (vco_max),
		.out_data (out_data)
	);

endmodule
`default_nettype wire
